// ===== hdl/tpcr_pkg.sv =====
`timescale 1ns / 1ps

package tpcr_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_LOOKUP      = 2'd0;
    localparam logic [1:0] OP_APPEND_TLB  = 2'd1;
    localparam logic [1:0] OP_APPEND_PAGE = 2'd2;
    localparam logic [1:0] OP_APPEND_LINE = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_HIT        = 3'd0;
    localparam logic [2:0] STAT_XLATE_MISS = 3'd1;
    localparam logic [2:0] STAT_CACHE_MISS = 3'd2;
    localparam logic [2:0] STAT_STORED     = 3'd3;
    localparam logic [2:0] STAT_FULL       = 3'd4;

    // Entry layouts: TLB {set, tag, ppn}, page {vpn, ppn}, line {set, tag, b3..b0}
    localparam int TLB_ENTRY_W  = 20;
    localparam int PAGE_ENTRY_W = 16;
    localparam int LINE_ENTRY_W = 44;

    // Width of the key fed to the shared comparator
    localparam int KEY_W = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TLB,
        ST_PAGE,
        ST_LINE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/tpcr_ram.sv =====
`timescale 1ns / 1ps

module tpcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/tlb_page_table_cache_read_core.sv =====
`timescale 1ns / 1ps

// Channel | signals                                            | direction
// --------+----------------------------------------------------+----------
// input   | in_valid, in_stall, operation, virtual_address,    | in (stall out)
//         | entry_index, entry_tag, entry_vpn, entry_ppn,      |
//         | line_byte0..line_byte3                             |
// output  | out_valid, out_stall, status, read_byte            | out (stall in)
//
// An append writes its table on the input transfer edge; the result then moves
// through ST_DONE into the output register.
// A lookup walks the TLB, then the page table only on a TLB miss, then the cache
// lines, one slot per cycle through one shared key comparator; the result then
// moves through ST_DONE into the output register.
// Reset clears the sequencer, the three fill counts and out_valid; table contents need none.
// in_stall stays high from the transfer until the result is in the output
// register; a stalled output holds the block in its final state.

module tlb_page_table_cache_read_core
    import tpcr_pkg::*;
#(
    parameter int TLB_SLOTS  = 16,
    parameter int PAGE_SLOTS = 64,
    parameter int LINE_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] virtual_address,
    input  logic [3:0]  entry_index,
    input  logic [7:0]  entry_tag,
    input  logic [7:0]  entry_vpn,
    input  logic [7:0]  entry_ppn,
    input  logic [7:0]  line_byte0,
    input  logic [7:0]  line_byte1,
    input  logic [7:0]  line_byte2,
    input  logic [7:0]  line_byte3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  read_byte
);

    localparam int TLB_AW  = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
    localparam int PAGE_AW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int LINE_AW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int TLB_FW  = $clog2(TLB_SLOTS + 1);
    localparam int PAGE_FW = $clog2(PAGE_SLOTS + 1);
    localparam int LINE_FW = $clog2(LINE_SLOTS + 1);
    localparam int MAX_TP  = (TLB_SLOTS > PAGE_SLOTS) ? TLB_SLOTS : PAGE_SLOTS;
    localparam int MAX_SLOTS = (MAX_TP > LINE_SLOTS) ? MAX_TP : LINE_SLOTS;
    localparam int SCAN_W  = $clog2(MAX_SLOTS + 1);

    // Sequencer and scan control
    state_t              state_reg, state_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                rd_valid_reg, rd_valid_next;

    // Table fill counts
    logic [TLB_FW-1:0]   tlb_fill_reg, tlb_fill_next;
    logic [PAGE_FW-1:0]  page_fill_reg, page_fill_next;
    logic [LINE_FW-1:0]  line_fill_reg, line_fill_next;

    // Lookup operands and pending result
    logic [13:0]         va_reg, va_next;
    logic [7:0]          ppn_reg, ppn_next;
    logic [2:0]          res_status_reg, res_status_next;
    logic [7:0]          res_byte_reg, res_byte_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg, status_next;
    logic [7:0]          byte_reg, byte_next;

    // Memory ports
    logic                    tlb_we, page_we, line_we;
    logic [TLB_ENTRY_W-1:0]  tlb_rdata;
    logic [PAGE_ENTRY_W-1:0] page_rdata;
    logic [LINE_ENTRY_W-1:0] line_rdata;

    // Shared comparator
    logic [KEY_W-1:0]    mem_key, want_key;
    logic                key_eq, hit_now, issue, scan_done;
    logic [SCAN_W-1:0]   cur_fill;
    logic                in_xfer;
    logic [7:0]          line_byte_sel;

    assign in_xfer = in_valid && !in_stall;

    tpcr_ram #(.WIDTH(TLB_ENTRY_W), .DEPTH(TLB_SLOTS)) u_tlb_ram (
        .clk   (clk),
        .we    (tlb_we),
        .waddr (tlb_fill_reg[TLB_AW-1:0]),
        .wdata ({entry_index, entry_tag, entry_ppn}),
        .raddr (scan_reg[TLB_AW-1:0]),
        .rdata (tlb_rdata)
    );

    tpcr_ram #(.WIDTH(PAGE_ENTRY_W), .DEPTH(PAGE_SLOTS)) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_fill_reg[PAGE_AW-1:0]),
        .wdata ({entry_vpn, entry_ppn}),
        .raddr (scan_reg[PAGE_AW-1:0]),
        .rdata (page_rdata)
    );

    tpcr_ram #(.WIDTH(LINE_ENTRY_W), .DEPTH(LINE_SLOTS)) u_line_ram (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_fill_reg[LINE_AW-1:0]),
        .wdata ({entry_index, entry_tag, line_byte3, line_byte2, line_byte1, line_byte0}),
        .raddr (scan_reg[LINE_AW-1:0]),
        .rdata (line_rdata)
    );

    // Pick the key pair for the current phase and compare it once per cycle
    always_comb
    begin
        mem_key  = '0;
        want_key = '0;
        cur_fill = '0;
        unique case (state_reg)
            ST_TLB:
            begin
                // stored set and tag are 4 and 8 bits; address fields are 2 and 6
                mem_key  = tlb_rdata[19:8];
                want_key = {2'b00, va_reg[7:6], 2'b00, va_reg[13:8]};
                cur_fill = SCAN_W'(tlb_fill_reg);
            end
            ST_PAGE:
            begin
                mem_key  = {4'b0000, page_rdata[15:8]};
                want_key = {4'b0000, va_reg[13:6]};
                cur_fill = SCAN_W'(page_fill_reg);
            end
            ST_LINE:
            begin
                mem_key  = line_rdata[43:32];
                want_key = {va_reg[5:2], ppn_reg};
                cur_fill = SCAN_W'(line_fill_reg);
            end
            default:
            begin
                mem_key  = '0;
                want_key = '0;
                cur_fill = '0;
            end
        endcase
    end

    assign key_eq    = (mem_key == want_key);
    assign hit_now   = rd_valid_reg && key_eq;
    assign issue     = (scan_reg < cur_fill) && !hit_now;
    assign scan_done = !rd_valid_reg && (scan_reg >= cur_fill);

    always_comb
    begin
        unique case (va_reg[1:0])
            2'd0: line_byte_sel = line_rdata[7:0];
            2'd1: line_byte_sel = line_rdata[15:8];
            2'd2: line_byte_sel = line_rdata[23:16];
            2'd3: line_byte_sel = line_rdata[31:24];
            default: line_byte_sel = '0;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        rd_valid_next   = 1'b0;
        tlb_fill_next   = tlb_fill_reg;
        page_fill_next  = page_fill_reg;
        line_fill_next  = line_fill_reg;
        va_next         = va_reg;
        ppn_next        = ppn_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        byte_next       = byte_reg;
        tlb_we          = 1'b0;
        page_we         = 1'b0;
        line_we         = 1'b0;
        in_stall        = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    res_byte_next = '0;
                    state_next    = ST_DONE;
                    unique case (operation)
                        OP_LOOKUP:
                        begin
                            va_next    = virtual_address[13:0];
                            scan_next  = '0;
                            state_next = ST_TLB;
                        end
                        OP_APPEND_TLB:
                        begin
                            if (tlb_fill_reg == TLB_FW'(TLB_SLOTS))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                tlb_we          = 1'b1;
                                tlb_fill_next   = tlb_fill_reg + 1'b1;
                                res_status_next = STAT_STORED;
                            end
                        end
                        OP_APPEND_PAGE:
                        begin
                            if (page_fill_reg == PAGE_FW'(PAGE_SLOTS))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                page_we         = 1'b1;
                                page_fill_next  = page_fill_reg + 1'b1;
                                res_status_next = STAT_STORED;
                            end
                        end
                        OP_APPEND_LINE:
                        begin
                            if (line_fill_reg == LINE_FW'(LINE_SLOTS))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else
                            begin
                                line_we         = 1'b1;
                                line_fill_next  = line_fill_reg + 1'b1;
                                res_status_next = STAT_STORED;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_FULL;
                        end
                    endcase
                end
            end
            ST_TLB:
            begin
                if (hit_now)
                begin
                    ppn_next   = tlb_rdata[7:0];
                    scan_next  = '0;
                    state_next = ST_LINE;
                end
                else if (scan_done)
                begin
                    scan_next  = '0;
                    state_next = ST_PAGE;
                end
                else if (issue)
                begin
                    scan_next     = scan_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
            end
            ST_PAGE:
            begin
                if (hit_now)
                begin
                    ppn_next   = page_rdata[7:0];
                    scan_next  = '0;
                    state_next = ST_LINE;
                end
                else if (scan_done)
                begin
                    res_status_next = STAT_XLATE_MISS;
                    res_byte_next   = '0;
                    state_next      = ST_DONE;
                end
                else if (issue)
                begin
                    scan_next     = scan_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
            end
            ST_LINE:
            begin
                if (hit_now)
                begin
                    res_status_next = STAT_HIT;
                    res_byte_next   = line_byte_sel;
                    state_next      = ST_DONE;
                end
                else if (scan_done)
                begin
                    res_status_next = STAT_CACHE_MISS;
                    res_byte_next   = '0;
                    state_next      = ST_DONE;
                end
                else if (issue)
                begin
                    scan_next     = scan_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    byte_next      = res_byte_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            tlb_fill_reg  <= '0;
            page_fill_reg <= '0;
            line_fill_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            rd_valid_reg  <= rd_valid_next;
            tlb_fill_reg  <= tlb_fill_next;
            page_fill_reg <= page_fill_next;
            line_fill_reg <= line_fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg         <= va_next;
        ppn_reg        <= ppn_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        status_reg     <= status_next;
        byte_reg       <= byte_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign read_byte = byte_reg;

    // A read in flight only exists inside a table walk
    a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_TLB || state_reg == ST_PAGE || state_reg == ST_LINE))
        else $error("slot read pending outside a table walk");

    // The walk pointer never runs past the fill count of the table it walks
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TLB || state_reg == ST_PAGE || state_reg == ST_LINE)
        |-> (scan_reg <= cur_fill))
        else $error("walk pointer beyond fill count");

    // Fill counts stay within their tables
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tlb_fill_reg <= TLB_FW'(TLB_SLOTS)) && (page_fill_reg <= PAGE_FW'(PAGE_SLOTS))
        && (line_fill_reg <= LINE_FW'(LINE_SLOTS)))
        else $error("fill count beyond table size");

    // An accepted TLB append into a table with room advances its fill count
    a_tlb_append: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && operation == OP_APPEND_TLB && tlb_fill_reg != TLB_FW'(TLB_SLOTS))
        |=> (tlb_fill_reg == $past(tlb_fill_reg) + 1'b1))
        else $error("TLB append did not advance fill count");

    // Only a hit carries a byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STAT_HIT) |-> (read_byte == 8'd0))
        else $error("non-hit result carries a byte");

endmodule
